// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the string prefix decoder modules
// depends on nothing; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/tlsp_pkg.sv -----
// types and constants of the string prefix decoder
// depends on nothing
package tlsp_pkg;

    localparam int LEN_W       = 56;
    localparam int ACCUM_LANES = 7;

    localparam logic [7:0] HDR_LONG  = 8'hff;
    localparam logic [7:0] HDR_MID   = 8'hfe;
    localparam logic [7:0] SHORT_MAX = 8'd253;

    localparam logic [2:0] LONG_BYTES = 3'd7;
    localparam logic [2:0] MID_BYTES  = 3'd3;
    localparam logic [2:0] MID_LAST_IDX = 3'd2;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_PAD     = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_TRUNC   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         out_byte;
        logic               last;
        logic [LEN_W-1:0]   length;
        logic               noncanonical;
    } result_t;

endpackage

// ----- rtl/core/tlsp_parser.sv -----
// header, payload and padding state machine of the string prefix decoder
// depends on tlsp_pkg and assert_macros.svh
`include "assert_macros.svh"

module tlsp_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_buffer,
    output logic                 res_valid,
    output tlsp_pkg::result_t    res
);

    tlsp_pkg::phase_t                 phase_reg, phase_next;
    logic [2:0]                       left_reg, left_next;
    logic [2:0]                       idx_reg, idx_next;
    logic [tlsp_pkg::LEN_W-1:0]       accum_reg, accum_next;
    logic [tlsp_pkg::LEN_W-1:0]       payload_reg, payload_next;
    logic [1:0]                       pad_reg, pad_next;
    logic                             nc_reg, nc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tlsp_pkg::PH_HEADER;
            left_reg    <= '0;
            idx_reg     <= '0;
            accum_reg   <= '0;
            payload_reg <= '0;
            pad_reg     <= '0;
            nc_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            idx_reg     <= idx_next;
            accum_reg   <= accum_next;
            payload_reg <= payload_next;
            pad_reg     <= pad_next;
            nc_reg      <= nc_next;
        end
    end

    always_comb
    begin
        logic       hdr_done;
        logic [1:0] size_lo;

        hdr_done     = 1'b0;
        size_lo      = 2'd0;
        phase_next   = phase_reg;
        left_next    = left_reg;
        idx_next     = idx_reg;
        accum_next   = accum_reg;
        payload_next = payload_reg;
        pad_next     = pad_reg;
        nc_next      = nc_reg;
        res_valid    = 1'b0;
        res.kind     = tlsp_pkg::KIND_PAYLOAD;
        res.out_byte = 8'd0;
        res.last     = 1'b0;

        unique case (phase_reg)
            tlsp_pkg::PH_HEADER:
            begin
                accum_next   = '0;
                idx_next     = '0;
                nc_next      = 1'b0;
                payload_next = '0;
                pad_next     = '0;
                if (in_byte == tlsp_pkg::HDR_LONG)
                begin
                    left_next  = tlsp_pkg::LONG_BYTES;
                    phase_next = tlsp_pkg::PH_LENGTH;
                end
                else if (in_byte == tlsp_pkg::HDR_MID)
                begin
                    left_next  = tlsp_pkg::MID_BYTES;
                    phase_next = tlsp_pkg::PH_LENGTH;
                end
                else
                begin
                    left_next  = '0;
                    accum_next = {{(tlsp_pkg::LEN_W-8){1'b0}}, in_byte};
                    hdr_done   = 1'b1;
                    size_lo    = 2'd1;
                end
            end
            tlsp_pkg::PH_LENGTH:
            begin
                // little-endian byte lane selected by the shift index
                for (int k = 0; k < tlsp_pkg::ACCUM_LANES; k++)
                begin
                    if (idx_reg == 3'(k))
                        accum_next[8*k +: 8] = accum_reg[8*k +: 8] | in_byte;
                end
                idx_next  = idx_reg + 3'd1;
                left_next = left_reg - 3'd1;
                if (left_next == 3'd0)
                begin
                    if (idx_reg == tlsp_pkg::MID_LAST_IDX)
                        nc_next = (accum_next <= tlsp_pkg::LEN_W'(tlsp_pkg::SHORT_MAX));
                    else
                        nc_next = (accum_next[tlsp_pkg::LEN_W-1:24] == '0);
                    hdr_done = 1'b1;
                    size_lo  = idx_reg[1:0] + 2'd2;
                end
            end
            tlsp_pkg::PH_PAYLOAD:
            begin
                payload_next = payload_reg - tlsp_pkg::LEN_W'(1);
                res_valid    = 1'b1;
                res.kind     = tlsp_pkg::KIND_PAYLOAD;
                res.out_byte = in_byte;
                res.last     = (payload_next == '0);
                if (payload_next == '0)
                    phase_next = (pad_reg != 2'd0) ? tlsp_pkg::PH_PAD : tlsp_pkg::PH_HEADER;
            end
            tlsp_pkg::PH_PAD:
            begin
                pad_next = pad_reg - 2'd1;
                if (pad_next == 2'd0)
                    phase_next = tlsp_pkg::PH_HEADER;
            end
            default:
            begin
                phase_next = tlsp_pkg::PH_HEADER;
            end
        endcase

        if (hdr_done)
        begin
            // padding brings header plus payload to a 4-byte boundary
            pad_next     = 2'd0 - (size_lo + accum_next[1:0]);
            payload_next = accum_next;
            if (accum_next == '0)
            begin
                phase_next = (pad_next != 2'd0) ? tlsp_pkg::PH_PAD : tlsp_pkg::PH_HEADER;
                res_valid  = 1'b1;
                res.kind   = tlsp_pkg::KIND_EMPTY;
                res.last   = 1'b1;
            end
            else
            begin
                phase_next = tlsp_pkg::PH_PAYLOAD;
            end
        end

        res.length       = accum_next;
        res.noncanonical = nc_next;

        // buffer ends with a string still open: single error item, full restart
        if (end_of_buffer && (phase_next != tlsp_pkg::PH_HEADER))
        begin
            phase_next       = tlsp_pkg::PH_HEADER;
            left_next        = '0;
            idx_next         = '0;
            accum_next       = '0;
            payload_next     = '0;
            pad_next         = '0;
            nc_next          = 1'b0;
            res_valid        = 1'b1;
            res.kind         = tlsp_pkg::KIND_TRUNC;
            res.out_byte     = 8'd0;
            res.last         = 1'b0;
            res.length       = '0;
            res.noncanonical = 1'b0;
        end
    end

    `ASSERT_CLK(a_trunc_restarts,
        step_en && res_valid && (res.kind == tlsp_pkg::KIND_TRUNC) |=>
        (phase_reg == tlsp_pkg::PH_HEADER) && (accum_reg == '0),
        "truncation did not return the parser to the header phase")
    `ASSERT_CLK(a_payload_in_phase,
        step_en && res_valid && (res.kind == tlsp_pkg::KIND_PAYLOAD) |->
        (phase_reg == tlsp_pkg::PH_PAYLOAD),
        "payload item outside the payload phase")
    `ASSERT_NEVER(a_length_count,
        (phase_reg == tlsp_pkg::PH_LENGTH) && (left_reg == 3'd0),
        "length phase with no length bytes left")
    `ASSERT_NEVER(a_pad_count,
        (phase_reg == tlsp_pkg::PH_PAD) && (pad_reg == 2'd0),
        "padding phase with no padding left")

endmodule

// ----- rtl/core/tl_string_prefix_decoder.sv -----
// top level of the length-prefixed string decoder: input register, parser, result register
// depends on tlsp_pkg, tlsp_parser and assert_macros.svh
//
// channel  dir  tdata                         tuser     tlast
// s_*      in   [7:0] in_byte                 -         end_of_buffer
// m_*      out  [7:0] out_byte, [63:8]        [1:0]     last_of_string
//               string_length, [64]           kind
//               noncanonical, [71:65] zero
//
// one item per cycle sustained while m_tready stays high; an accepted item goes into the input
// register, then through one parser step into the result register
// the parser handles one byte per cycle while advance is high: a phase update, a 56-bit count-down and
// a byte-lane merge of the length
// rst_n is asynchronous and active low; there is no clearing pass after reset
// a stall on m_tready backs up through the result and input registers, so
// s_tready drops only when both hold an item and m_tready is low
`include "assert_macros.svh"

module tl_string_prefix_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [7:0] out_byte, [63:8] string_length, [64] noncanonical
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast     // last_of_string
);

    logic                    in_valid_reg, in_valid_next;
    logic [7:0]              in_byte_reg;
    logic                    in_eob_reg;
    logic                    out_valid_reg, out_valid_next;
    tlsp_pkg::result_t       out_res_reg;
    logic                    advance;
    logic                    s_take;
    logic                    res_valid;
    tlsp_pkg::result_t       res;

    // the parser steps whenever the input register holds a byte and the result register can take what it makes
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = res_valid;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_byte_reg <= s_tdata;
            in_eob_reg  <= s_tlast;
        end
        if (advance && res_valid)
            out_res_reg <= res;
    end

    tlsp_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (advance),
        .in_byte       (in_byte_reg),
        .end_of_buffer (in_eob_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg.noncanonical, out_res_reg.length, out_res_reg.out_byte};
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last;

    `ASSERT_CLK(a_ready_only_when_full,
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready,
        "input held off while the pipeline has room")
    `ASSERT_CLK(a_step_fills_output,
        advance && res_valid |=> out_valid_reg,
        "parser result lost on its way to the result register")

endmodule
